// ===== src/tgc_pkg.sv =====
// Package for the tiled gradient coherence block: widths, register indexes,
// sequencer states and the packed tile-sum record.
// Depends on nothing; the design files use it by scoped names, the testbench by import.
package tgc_pkg;

    localparam int MAX_WIDTH = 4096;
    localparam int ROW_LIMIT = 4096;
    localparam int TILE_SIZE = 16;
    localparam int TILE_LOG  = 4;
    localparam int COL_W     = 12;
    localparam int TILE_IW   = 8;
    localparam int TILE_COLS = 256;
    localparam int SUM_W     = 25;
    localparam int XY_W      = 26;
    localparam int TOT_W     = 42;
    localparam int RAD_W     = 52;
    localparam int ROOT_W    = 26;
    localparam int NUM_W     = 59;
    localparam int Q_W       = 17;
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;

    localparam logic [Q_W-1:0]       ONE_Q16      = 17'h10000;
    localparam logic [CFG_W-1:0]     WIDTH_RESET  = 13'd1920;
    localparam logic [CFG_W-1:0]     HEIGHT_RESET = 13'd1080;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD2,
        ST_GRAD,
        ST_MUL,
        ST_ACC,
        ST_SQ1,
        ST_SQ2,
        ST_SQ3,
        ST_SQW,
        ST_END,
        ST_DIVW
    } tgc_state_t;

    typedef struct packed {
        logic [XY_W-1:0]  xy;
        logic [SUM_W-1:0] yy;
        logic [SUM_W-1:0] xx;
    } tile_sums_t;

endpackage

// ===== src/tgc_isqrt.sv =====
// Iterative floor square root, one result bit per cycle.
// Depends on tgc_pkg for the radicand and root widths.
module tgc_isqrt
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [tgc_pkg::RAD_W-1:0]    radicand,
    output logic                         done,
    output logic [tgc_pkg::ROOT_W-1:0]   root
);

    logic                        run_reg;
    logic                        done_reg;
    logic [4:0]                  cnt_reg;
    logic [tgc_pkg::RAD_W-1:0]   rad_reg;
    logic [tgc_pkg::ROOT_W+2:0]  rem_reg;
    logic [tgc_pkg::ROOT_W-1:0]  root_reg;

    logic [tgc_pkg::ROOT_W+2:0]  rem_sh;
    logic [tgc_pkg::ROOT_W+2:0]  trial;

    // One digit step: bring down two radicand bits and try the next root bit.
    assign rem_sh = {rem_reg[tgc_pkg::ROOT_W:0], rad_reg[tgc_pkg::RAD_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};

    // Control: counter and handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 5'(tgc_pkg::ROOT_W - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: remainder, root and the shifting radicand.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            rad_reg <= {rad_reg[tgc_pkg::RAD_W-3:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[tgc_pkg::ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[tgc_pkg::ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== src/tgc_div.sv =====
// Restoring divider, one quotient bit per cycle, for the frame-end ratio.
// Depends on tgc_pkg for the dividend and divisor widths.
module tgc_div
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [tgc_pkg::NUM_W-1:0]   dividend,
    input  logic [tgc_pkg::TOT_W-1:0]   divisor,
    output logic                        done,
    output logic [tgc_pkg::NUM_W-1:0]   quotient
);

    logic                        run_reg;
    logic                        done_reg;
    logic [5:0]                  cnt_reg;
    logic [tgc_pkg::NUM_W-1:0]   num_reg;
    logic [tgc_pkg::TOT_W-1:0]   den_reg;
    logic [tgc_pkg::TOT_W-1:0]   rem_reg;

    logic [tgc_pkg::TOT_W:0]     rem_sh;
    logic [tgc_pkg::TOT_W:0]     rem_sub;

    // The dividend shifts out at the top while quotient bits enter below.
    assign rem_sh  = {rem_reg, num_reg[tgc_pkg::NUM_W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};

    // Control: counter and handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= 6'(tgc_pkg::NUM_W - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder, and dividend and quotient sharing one shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (run_reg)
        begin
            if (rem_sh >= {1'b0, den_reg})
            begin
                rem_reg <= rem_sub[tgc_pkg::TOT_W-1:0];
                num_reg <= {num_reg[tgc_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[tgc_pkg::TOT_W-1:0];
                num_reg <= {num_reg[tgc_pkg::NUM_W-2:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = num_reg;

endmodule

// ===== src/tiled_gradient_coherence.sv =====
// Tiled gradient coherence: pixels in raster order, one ratio per frame.
// A border pixel passes through the read-modify-write of the line memories and an
// interior pixel also through that of the tile-sum memory, busy holding off the next
// pixel; a pixel that closes a tile adds the 26-step square root, and the frame's last
// pixel adds the 59-step divider when the weight sum is nonzero. The result strobe lasts one
// cycle, in the first idle cycle after the last pixel; no stall.
// Reset clears counters, totals and tile valid bits at once; line memories need none.
module tiled_gradient_coherence
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [7:0]                      pixel,
    output logic                            done,
    output logic [tgc_pkg::Q_W-1:0]         coherence_q16,
    output logic                            flat_frame,
    input  logic                            cfg_we,
    input  logic [tgc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tgc_pkg::CFG_W-1:0]       cfg_data
);

    // Control registers.
    tgc_pkg::tgc_state_t             state_reg, state_next;
    logic [tgc_pkg::CFG_W-1:0]       fw_reg, fw_next;
    logic [tgc_pkg::CFG_W-1:0]       fh_reg, fh_next;
    logic [tgc_pkg::COL_W-1:0]       row_reg, row_next;
    logic [tgc_pkg::COL_W-1:0]       col_reg, col_next;
    logic [tgc_pkg::TOT_W-1:0]       coh_reg, coh_next;
    logic [tgc_pkg::TOT_W-1:0]       wt_reg, wt_next;
    logic [tgc_pkg::TILE_COLS-1:0]   valid_reg, valid_next;
    logic                            done_reg, done_next;
    logic                            flat_reg, flat_next;
    logic [tgc_pkg::Q_W-1:0]         q_reg, q_next;

    // Per-pixel datapath registers.
    logic [7:0]                      pix_reg;
    logic                            odd_reg;
    logic [tgc_pkg::COL_W-1:0]       pcol_reg;
    logic [tgc_pkg::TILE_IW-1:0]     t_reg;
    logic                            interior_reg;
    logic                            close_reg;
    logic                            last_reg;
    logic [7:0]                      own_reg;
    logic [7:0]                      left_reg;
    logic signed [8:0]               gx_reg;
    logic signed [8:0]               gy_reg;
    logic signed [17:0]              pxx_reg;
    logic signed [17:0]              pyy_reg;
    logic signed [17:0]              pxy_reg;
    tgc_pkg::tile_sums_t             sums_reg;
    logic [tgc_pkg::RAD_W-1:0]       dd_reg;
    logic [tgc_pkg::RAD_W-1:0]       xy2_reg;
    logic [tgc_pkg::RAD_W-1:0]       mag;

    // Memories and their registered read data.
    logic [7:0]                      line_above [tgc_pkg::MAX_WIDTH];
    logic [7:0]                      line_current [tgc_pkg::MAX_WIDTH];
    tgc_pkg::tile_sums_t             tile_mem [tgc_pkg::TILE_COLS];
    logic [7:0]                      a_q_reg;
    logic [7:0]                      b_q_reg;
    tgc_pkg::tile_sums_t             tile_q_reg;

    // Clamped frame geometry.
    logic [tgc_pkg::CFG_W-1:0]       w_eff;
    logic [tgc_pkg::CFG_W-1:0]       h_eff;
    logic [tgc_pkg::COL_W-1:0]       w_m1, w_m2, h_m1;
    logic                            w_ge3;
    logic                            accept;
    logic [tgc_pkg::COL_W-1:0]       col_m1, col_p1, row_m2;
    logic                            interior_now;
    logic                            close_now;
    logic                            last_now;
    logic                            cfg_hit;

    // Addresses and enables for the line memories.
    logic                            a_re, b_re, a_we, b_we;
    logic [tgc_pkg::COL_W-1:0]       a_addr, b_addr;

    // Close and finish arithmetic.
    tgc_pkg::tile_sums_t             base_sums;
    tgc_pkg::tile_sums_t             new_sums;
    logic signed [tgc_pkg::XY_W-1:0] diff;
    logic signed [2*tgc_pkg::XY_W-1:0] diff_sq;
    logic signed [2*tgc_pkg::XY_W-1:0] xy_sq;
    logic [tgc_pkg::NUM_W-1:0]       dividend;
    logic                            sqrt_start, sqrt_done;
    logic [tgc_pkg::ROOT_W-1:0]      root;
    logic                            div_start, div_done;
    logic [tgc_pkg::NUM_W-1:0]       quotient;

    function automatic logic [tgc_pkg::XY_W-1:0] XY_EXT(input logic signed [17:0] p);
        XY_EXT = {{(tgc_pkg::XY_W-18){p[17]}}, p};
    endfunction

    // Geometry: zero is one, oversize is the limit.
    always_comb
    begin
        if (fw_reg == '0)
            w_eff = 13'd1;
        else if (fw_reg > 13'(tgc_pkg::MAX_WIDTH))
            w_eff = 13'(tgc_pkg::MAX_WIDTH);
        else
            w_eff = fw_reg;
        if (fh_reg == '0)
            h_eff = 13'd1;
        else if (fh_reg > 13'(tgc_pkg::ROW_LIMIT))
            h_eff = 13'(tgc_pkg::ROW_LIMIT);
        else
            h_eff = fh_reg;
    end

    assign w_m1  = 12'(w_eff - 13'd1);
    assign w_m2  = 12'(w_eff - 13'd2);
    assign h_m1  = 12'(h_eff - 13'd1);
    assign w_ge3 = (w_eff >= 13'd3);

    // Position of the incoming pixel and its role in the tiling.
    assign accept       = start && (state_reg == tgc_pkg::ST_IDLE);
    assign col_m1       = col_reg - 12'd1;
    assign col_p1       = col_reg + 12'd1;
    assign row_m2       = row_reg - 12'd2;
    assign interior_now = (row_reg >= 12'd2) && w_ge3 && (col_reg >= 12'd1)
                          && (col_reg <= w_m2);
    assign close_now    = ((row_m2[tgc_pkg::TILE_LOG-1:0] == 4'hF) || (row_reg == h_m1))
                          && ((col_m1[tgc_pkg::TILE_LOG-1:0] == 4'hF) || (col_reg == w_m2));
    assign last_now     = (row_reg == h_m1) && (col_reg == w_m1);
    assign cfg_hit      = cfg_we && ((cfg_index == tgc_pkg::REG_WIDTH)
                          || (cfg_index == tgc_pkg::REG_HEIGHT));

    // Line memory ports: own column and left neighbor at accept, right neighbor
    // and own write-back in the next cycle. Odd rows live in line_above.
    always_comb
    begin
        a_re   = 1'b0;
        b_re   = 1'b0;
        a_we   = 1'b0;
        b_we   = 1'b0;
        a_addr = col_reg;
        b_addr = col_reg;
        if (accept)
        begin
            a_re   = 1'b1;
            b_re   = 1'b1;
            a_addr = row_reg[0] ? col_reg : col_m1;
            b_addr = row_reg[0] ? col_m1 : col_reg;
        end
        else if (state_reg == tgc_pkg::ST_RD2)
        begin
            a_we   = odd_reg;
            b_we   = !odd_reg;
            a_re   = !odd_reg;
            b_re   = odd_reg;
            a_addr = odd_reg ? pcol_reg : pcol_reg + 12'd1;
            b_addr = odd_reg ? pcol_reg + 12'd1 : pcol_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_we)
            line_above[a_addr] <= pix_reg;
        if (a_re)
            a_q_reg <= line_above[a_addr];
    end

    always_ff @(posedge clk)
    begin
        if (b_we)
            line_current[b_addr] <= pix_reg;
        if (b_re)
            b_q_reg <= line_current[b_addr];
    end

    // Tile sums: read at accept, written back after accumulation unless the
    // tile closes, in which case its valid bit drops.
    assign base_sums   = valid_reg[t_reg] ? tile_q_reg : '0;
    assign new_sums.xx = base_sums.xx + 25'(pxx_reg[15:0]);
    assign new_sums.yy = base_sums.yy + 25'(pyy_reg[15:0]);
    assign new_sums.xy = base_sums.xy + XY_EXT(pxy_reg);

    always_ff @(posedge clk)
    begin
        if (accept)
            tile_q_reg <= tile_mem[col_m1[tgc_pkg::COL_W-1:tgc_pkg::TILE_LOG]];
        if (state_reg == tgc_pkg::ST_ACC && !close_reg)
            tile_mem[t_reg] <= new_sums;
    end

    // Gradient, product and tile-close datapath.
    assign diff    = $signed({1'b0, sums_reg.xx}) - $signed({1'b0, sums_reg.yy});
    assign diff_sq = diff * diff;
    assign xy_sq   = $signed(sums_reg.xy) * $signed(sums_reg.xy);
    assign mag     = dd_reg + {xy2_reg[tgc_pkg::RAD_W-3:0], 2'b00};

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pix_reg      <= pixel;
            odd_reg      <= row_reg[0];
            pcol_reg     <= col_reg;
            t_reg        <= col_m1[tgc_pkg::COL_W-1:tgc_pkg::TILE_LOG];
            interior_reg <= interior_now;
            close_reg    <= close_now;
            last_reg     <= last_now;
        end
        if (state_reg == tgc_pkg::ST_RD2)
        begin
            own_reg  <= odd_reg ? a_q_reg : b_q_reg;
            left_reg <= odd_reg ? b_q_reg : a_q_reg;
        end
        if (state_reg == tgc_pkg::ST_GRAD)
        begin
            gx_reg <= $signed({1'b0, (odd_reg ? b_q_reg : a_q_reg)}) - $signed({1'b0, left_reg});
            gy_reg <= $signed({1'b0, pix_reg}) - $signed({1'b0, own_reg});
        end
        if (state_reg == tgc_pkg::ST_MUL)
        begin
            pxx_reg <= gx_reg * gx_reg;
            pyy_reg <= gy_reg * gy_reg;
            pxy_reg <= gx_reg * gy_reg;
        end
        if (state_reg == tgc_pkg::ST_ACC)
            sums_reg <= new_sums;
        if (state_reg == tgc_pkg::ST_SQ1)
            dd_reg <= 52'(diff_sq);
        if (state_reg == tgc_pkg::ST_SQ2)
            xy2_reg <= 52'(xy_sq);
    end

    assign dividend = {1'b0, coh_reg, 16'h0000}
                      + {18'h0, wt_reg[tgc_pkg::TOT_W-1:1]};

    tgc_isqrt u_isqrt
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (mag),
        .done     (sqrt_done),
        .root     (root)
    );

    tgc_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (wt_reg),
        .done     (div_done),
        .quotient (quotient)
    );

    // Sequencer: next state, counters, totals and the result beat.
    always_comb
    begin
        state_next = state_reg;
        fw_next    = fw_reg;
        fh_next    = fh_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        coh_next   = coh_reg;
        wt_next    = wt_reg;
        valid_next = valid_reg;
        done_next  = 1'b0;
        flat_next  = flat_reg;
        q_next     = q_reg;
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            tgc_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = tgc_pkg::ST_RD2;
            end
            tgc_pkg::ST_RD2:
            begin
                state_next = interior_reg ? tgc_pkg::ST_GRAD : tgc_pkg::ST_END;
            end
            tgc_pkg::ST_GRAD:
            begin
                state_next = tgc_pkg::ST_MUL;
            end
            tgc_pkg::ST_MUL:
            begin
                state_next = tgc_pkg::ST_ACC;
            end
            tgc_pkg::ST_ACC:
            begin
                valid_next[t_reg] = !close_reg;
                state_next = close_reg ? tgc_pkg::ST_SQ1 : tgc_pkg::ST_END;
            end
            tgc_pkg::ST_SQ1:
            begin
                wt_next = wt_reg + 42'(sums_reg.xx) + 42'(sums_reg.yy);
                state_next = tgc_pkg::ST_SQ2;
            end
            tgc_pkg::ST_SQ2:
            begin
                state_next = tgc_pkg::ST_SQ3;
            end
            tgc_pkg::ST_SQ3:
            begin
                // Both squared terms are in place; the root takes the first plus four times the second now.
                sqrt_start = 1'b1;
                state_next = tgc_pkg::ST_SQW;
            end
            tgc_pkg::ST_SQW:
            begin
                if (sqrt_done)
                begin
                    coh_next   = coh_reg + 42'(root);
                    state_next = tgc_pkg::ST_END;
                end
            end
            tgc_pkg::ST_END:
            begin
                if (!last_reg)
                begin
                    if (col_reg == w_m1)
                    begin
                        col_next = '0;
                        row_next = row_reg + 12'd1;
                    end
                    else
                        col_next = col_reg + 12'd1;
                    state_next = tgc_pkg::ST_IDLE;
                end
                else if (wt_reg == '0)
                begin
                    done_next  = 1'b1;
                    flat_next  = 1'b1;
                    q_next     = tgc_pkg::ONE_Q16;
                    row_next   = '0;
                    col_next   = '0;
                    coh_next   = '0;
                    wt_next    = '0;
                    valid_next = '0;
                    state_next = tgc_pkg::ST_IDLE;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = tgc_pkg::ST_DIVW;
                end
            end
            tgc_pkg::ST_DIVW:
            begin
                if (div_done)
                begin
                    done_next  = 1'b1;
                    flat_next  = 1'b0;
                    q_next     = (quotient > 59'(tgc_pkg::ONE_Q16))
                                 ? tgc_pkg::ONE_Q16 : quotient[tgc_pkg::Q_W-1:0];
                    row_next   = '0;
                    col_next   = '0;
                    coh_next   = '0;
                    wt_next    = '0;
                    valid_next = '0;
                    state_next = tgc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tgc_pkg::ST_IDLE;
            end
        endcase

        // A write to the width or height register aborts the frame in progress.
        if (cfg_hit)
        begin
            if (cfg_index == tgc_pkg::REG_WIDTH)
                fw_next = cfg_data;
            else
                fh_next = cfg_data;
            row_next   = '0;
            col_next   = '0;
            coh_next   = '0;
            wt_next    = '0;
            valid_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tgc_pkg::ST_IDLE;
            fw_reg    <= tgc_pkg::WIDTH_RESET;
            fh_reg    <= tgc_pkg::HEIGHT_RESET;
            row_reg   <= '0;
            col_reg   <= '0;
            coh_reg   <= '0;
            wt_reg    <= '0;
            valid_reg <= '0;
            done_reg  <= 1'b0;
            flat_reg  <= 1'b0;
            q_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fw_reg    <= fw_next;
            fh_reg    <= fh_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            coh_reg   <= coh_next;
            wt_reg    <= wt_next;
            valid_reg <= valid_next;
            done_reg  <= done_next;
            flat_reg  <= flat_next;
            q_reg     <= q_next;
        end
    end

    assign busy          = (state_reg != tgc_pkg::ST_IDLE);
    assign done          = done_reg;
    assign coherence_q16 = q_reg;
    assign flat_frame    = flat_reg;

    // A result beat always leaves the block at the start of a fresh frame.
    a_done_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (row_reg == '0 && col_reg == '0 && wt_reg == '0))
        else $error("result beat without a frame restart");

    // A flat frame reports exactly one.
    a_flat_one: assert property (@(posedge clk) disable iff (!rst_n)
        (done && flat_frame) |-> (coherence_q16 == tgc_pkg::ONE_Q16))
        else $error("flat frame with a ratio other than one");

    // The ratio is capped at one.
    a_ratio_cap: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (coherence_q16 <= tgc_pkg::ONE_Q16))
        else $error("ratio above one");

    // An accepted pixel always occupies the block in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted pixel left the block idle");

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for tiled_gradient_coherence: drives pixel frames and
// register writes, predicts each per-frame coherence result and compares it.
// Depends on tgc_pkg and the tiled_gradient_coherence top module.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tgc_pkg::*;

    // Register indexes past the two real registers; writes there do nothing.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam int SETTLE_CYCLES = 120;

    typedef enum int {PAT_RANDOM, PAT_FLAT, PAT_CHECKER, PAT_RAMP, PAT_ZERO} pattern_t;

    typedef struct {
        logic [Q_W-1:0] ratio;
        logic           flat;
    } frame_result_t;

    // Coherence predictor and store of expected frame results.
    class coherence_scoreboard;
        logic [7:0]      rows_odd [MAX_WIDTH];
        logic [7:0]      rows_even[MAX_WIDTH];
        logic [31:0]     sum_xx[TILE_COLS+1];
        logic [31:0]     sum_yy[TILE_COLS+1];
        int              sum_xy[TILE_COLS+1];
        longint unsigned coh_total;
        longint unsigned weight_total;
        int unsigned     position;
        int unsigned     width_reg;
        int unsigned     height_reg;
        frame_result_t   expected_frames[$];
        int              errors;
        int              frames_checked;
        int              flat_frames;

        function new();
            width_reg = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            errors = 0;
            frames_checked = 0;
            flat_frames = 0;
            clear_frame();
        endfunction

        function void clear_frame();
            for (int i = 0; i <= TILE_COLS; i++)
            begin
                sum_xx[i] = 0;
                sum_yy[i] = 0;
                sum_xy[i] = 0;
            end
            coh_total = 0;
            weight_total = 0;
            position = 0;
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            if (height_reg == 0) return 1;
            if (height_reg > ROW_LIMIT) return ROW_LIMIT;
            return height_reg;
        endfunction

        function int pending();
            return expected_frames.size();
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_WIDTH)
                width_reg = 32'(val);
            else if (idx == REG_HEIGHT)
                height_reg = 32'(val);
            else
                return;
            clear_frame();
        endfunction

        // Bitwise floor square root; the root never exceeds 32 bits here.
        function longint unsigned root_floor(longint unsigned n);
            longint unsigned r;
            longint unsigned c;
            r = 0;
            for (int b = 31; b >= 0; b--)
            begin
                c = r | (64'd1 << b);
                if (c * c <= n) r = c;
            end
            return r;
        endfunction

        function void close_tile(int unsigned t);
            longint d;
            longint xy;
            longint unsigned mag;
            d = longint'(sum_xx[t]) - longint'(sum_yy[t]);
            xy = longint'(sum_xy[t]);
            mag = longint'(d * d) + 4 * longint'(xy * xy);
            coh_total = (coh_total + root_floor(mag)) & ((64'd1 << TOT_W) - 1);
            weight_total = (weight_total + sum_xx[t] + sum_yy[t]) & ((64'd1 << TOT_W) - 1);
            sum_xx[t] = 0;
            sum_yy[t] = 0;
            sum_xy[t] = 0;
        endfunction

        // One accepted pixel: update gradients, tiles and, at frame end, the ratio.
        function void note_pixel(logic [7:0] pix);
            int unsigned w, h, row, col, yc, t;
            int gx, gy;
            logic [7:0] above, two_above, left, right;
            longint unsigned q;
            frame_result_t res;
            w = eff_width();
            h = eff_height();
            if (position >= w * h) position = 0;
            row = position / w;
            col = position % w;
            if (row >= 2 && w >= 3 && col >= 1 && col <= w - 2)
            begin
                // Row just above sits in the other store, row two above in our own.
                left  = row[0] ? rows_even[col-1] : rows_odd[col-1];
                right = row[0] ? rows_even[col+1] : rows_odd[col+1];
                two_above = row[0] ? rows_odd[col] : rows_even[col];
                gx = int'(right) - int'(left);
                gy = int'(pix) - int'(two_above);
                yc = row - 1;
                t = (col - 1) / TILE_SIZE;
                sum_xx[t] += gx * gx;
                sum_yy[t] += gy * gy;
                sum_xy[t] += gx * gy;
                if ((((yc - 1) % TILE_SIZE) == TILE_SIZE - 1 || yc == h - 2) &&
                    (((col - 1) % TILE_SIZE) == TILE_SIZE - 1 || col == w - 2))
                    close_tile(t);
            end
            if (row[0]) rows_odd[col] = pix;
            else rows_even[col] = pix;
            if (position + 1 < w * h)
            begin
                position++;
                return;
            end
            if (weight_total == 0)
            begin
                res.ratio = ONE_Q16;
                res.flat = 1'b1;
            end
            else
            begin
                q = ((coh_total << 16) + (weight_total >> 1)) / weight_total;
                if (q > ONE_Q16) q = ONE_Q16;
                res.ratio = q[Q_W-1:0];
                res.flat = 1'b0;
            end
            expected_frames.push_back(res);
            clear_frame();
        endfunction

        task report(string what);
            $display("MISMATCH at %0t: %s", $realtime, what);
            errors++;
        endtask

        task check_result(logic [Q_W-1:0] ratio, logic flat);
            frame_result_t exp_res;
            if (expected_frames.size() == 0)
            begin
                report($sformatf("unexpected result ratio=%0d flat=%0b", ratio, flat));
                return;
            end
            exp_res = expected_frames.pop_front();
            frames_checked++;
            if (exp_res.flat) flat_frames++;
            if (ratio !== exp_res.ratio)
                report($sformatf("coherence_q16 %0d, expected %0d", ratio, exp_res.ratio));
            if (flat !== exp_res.flat)
                report($sformatf("flat_frame %0b, expected %0b", flat, exp_res.flat));
        endtask
    endclass

    logic                 clk;
    logic                 rst_n;
    logic                 start;
    logic                 busy;
    logic [7:0]           pixel;
    logic                 done;
    logic [Q_W-1:0]       coherence_q16;
    logic                 flat_frame;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    coherence_scoreboard sb;
    int  pixels_sent;
    bit  gaps_on;

    tiled_gradient_coherence dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .pixel         (pixel),
        .done          (done),
        .coherence_q16 (coherence_q16),
        .flat_frame    (flat_frame),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result monitor: each strobed beat is checked at the edge ending it.
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(coherence_q16, flat_frame);
    end

    // Hard limit on the run.
    initial
    begin
        #30ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [7:0] pattern_pixel(pattern_t pat, int i, int w);
        case (pat)
            PAT_FLAT:    return 8'hFF;
            PAT_ZERO:    return 8'h00;
            PAT_CHECKER: return (((i % w) + (i / w)) % 2) ? 8'hFF : 8'h00;
            PAT_RAMP:    return 8'((i % w) * 7 + (i / w) * 3);
            default:     return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Send one pixel beat, after a random idle gap when gaps are on; start stays high across
    // back-to-back beats.
    task automatic send_pixel(logic [7:0] v);
        int gap;
        gap = gaps_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        pixel <= v;
        do @(posedge clk); while (busy);
        sb.note_pixel(v);
        pixels_sent++;
    endtask

    task automatic send_pixels(int count, pattern_t pat);
        int w;
        w = sb.eff_width();
        gaps_on = ($urandom_range(0, 3) != 0);
        for (int i = 0; i < count; i++)
            send_pixel(pattern_pixel(pat, i, w));
        start <= 1'b0;
    endtask

    // Wait for every expected result, then let the block settle.
    task automatic wait_idle();
        int k;
        k = 0;
        while (sb.pending() > 0 && k < 400000)
        begin
            @(posedge clk);
            k++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic set_frame(int w, int h);
        write_reg(REG_WIDTH, CFG_W'(w));
        write_reg(REG_HEIGHT, CFG_W'(h));
    endtask

    task automatic run_frame(int w, int h, pattern_t pat);
        set_frame(w, h);
        send_pixels(sb.eff_width() * sb.eff_height(), pat);
        wait_idle();
    endtask

    initial
    begin
        int w, h, n;
        pattern_t pat;
        sb = new();
        pixels_sent = 0;
        gaps_on = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        pixel = 8'h00;
        cfg_we = 1'b0;
        cfg_index = REG_WIDTH;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge clk);

        // Directed: small frames, all zero, full-swing checkerboard, then flat.
        run_frame(8, 3, PAT_ZERO);
        run_frame(8, 3, PAT_CHECKER);
        run_frame(8, 4, PAT_FLAT);
        // Zero sizes are taken as one: a single-pixel flat frame.
        run_frame(0, 0, PAT_RANDOM);
        // Too narrow or too short for any interior.
        run_frame(2, 9, PAT_CHECKER);
        run_frame(9, 2, PAT_CHECKER);
        // A width not a multiple of eight, then one that is; both span more than one tile column.
        run_frame(21, 19, PAT_RAMP);
        run_frame(24, 6, PAT_RANDOM);
        // Spare register indexes leave the frame in progress alone.
        set_frame(16, 4);
        send_pixels(30, PAT_RANDOM);
        wait_idle();
        write_reg(REG_SPARE_A, 13'h1FFF);
        write_reg(REG_SPARE_B, 13'h0AAA);
        send_pixels(34, PAT_RANDOM);
        wait_idle();
        // A real register write aborts a partial frame.
        send_pixels(20, PAT_CHECKER);
        wait_idle();
        write_reg(REG_HEIGHT, 13'd5);
        send_pixels(80, PAT_RANDOM);
        wait_idle();
        // Oversized register values: partial frames, each ended by the next write.
        set_frame(13'h1FFF, 3);
        send_pixels(60, PAT_RANDOM);
        wait_idle();
        set_frame(8, 13'h1FFF);
        send_pixels(160, PAT_RAMP);
        wait_idle();

        // Random frames, mostly small, some aborted, some repeated.
        while (pixels_sent < 1600)
        begin
            w = ($urandom_range(0, 3) != 0) ? 8 * $urandom_range(1, 4) : $urandom_range(0, 40);
            h = ($urandom_range(0, 15) != 0) ? $urandom_range(1, 8) : 0;
            case ($urandom_range(0, 3))
                0: pat = PAT_RAMP;
                1: pat = PAT_CHECKER;
                default: pat = PAT_RANDOM;
            endcase
            set_frame(w, h);
            n = sb.eff_width() * sb.eff_height();
            if ($urandom_range(0, 7) == 0)
                n = $urandom_range(1, n);
            else if ($urandom_range(0, 3) == 0)
                n = 2 * n;
            send_pixels(n, pat);
            wait_idle();
        end

        wait_idle();
        if (sb.pending() > 0)
            sb.report($sformatf("%0d expected results never arrived", sb.pending()));
        $display("Run covered %0d pixel beats and %0d frame results (%0d flat),",
                 pixels_sent, sb.frames_checked, sb.flat_frames);
        $display("with aborted frames, spare register writes and oversized sizes.");
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
